// ----- design/hashed_id_registry_unit_assert.svh -----
// Assertion macros for the hashed id registry.
// Used by modules clocked on i_clk with the synchronous active-low reset i_rst_n.
`ifndef HASHED_ID_REGISTRY_UNIT_ASSERT_SVH
`define HASHED_ID_REGISTRY_UNIT_ASSERT_SVH

// Check that a condition implies another in the same cycle.
`define HIR_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("hir: same-cycle check failed");

// Check that a condition implies another in the next cycle.
`define HIR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("hir: next-cycle check failed");

`endif

// ----- design/hir_pkg.sv -----
// Shared types and constants for the hashed id registry.
// No dependencies; used by the interfaces, the registry unit and the hash.
package hir_pkg;

    // table geometry
    localparam int TABLE_SLOTS = 64;
    localparam int MAX_ENTRIES = 64;
    localparam int ID_BITS     = 32;

    // field widths
    localparam int EXT_ID_W = 32;
    localparam int HANDLE_W = 64;
    localparam int SLOT_OUT_W = 6;
    localparam int KEY_W    = (ID_BITS < EXT_ID_W) ? ID_BITS : EXT_ID_W;
    localparam int SLOT_W   = $clog2(TABLE_SLOTS);
    localparam int HOME_W   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int COUNT_W  = $clog2(MAX_ENTRIES + 1);
    localparam int ENTRY_W  = KEY_W + HANDLE_W;
    localparam int HASH_W   = 64;

    // last slot of the probe, which never wraps
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TABLE_SLOTS - 1);

    localparam logic [HASH_W-1:0] HASH_XOR_MASK = 64'h0000_0000_7FFF_FFFF;

    // opcodes
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        CS_IDLE,
        CS_HASH,
        CS_SCAN,
        CS_DONE
    } t_ctl_state;

    typedef enum logic [2:0] {
        HS_IDLE,
        HS_ADD18,
        HS_XOR31,
        HS_MUL21,
        HS_XOR11,
        HS_ADD6,
        HS_XOR22,
        HS_DONE
    } t_hash_step;

endpackage

// ----- design/hir_req_if.sv -----
// Request channel of the hashed id registry: opcode, id and handle.
// Depends on hir_pkg for field widths.
interface hir_req_if;
    logic                          valid;
    logic                          ready;
    logic                          opcode;
    logic [hir_pkg::EXT_ID_W-1:0]  ext_id;
    logic [hir_pkg::HANDLE_W-1:0]  handle_in;

    modport source (output valid, output opcode, output ext_id, output handle_in,
                    input ready);
    modport sink   (input valid, input opcode, input ext_id, input handle_in,
                    output ready);
endinterface

// ----- design/hir_rsp_if.sv -----
// Response channel of the hashed id registry: status, handle and slot.
// Depends on hir_pkg for field widths.
interface hir_rsp_if;
    logic                            valid;
    logic                            ready;
    logic [1:0]                      status;
    logic [hir_pkg::HANDLE_W-1:0]    handle_out;
    logic [hir_pkg::SLOT_OUT_W-1:0]  slot_index;

    modport source (output valid, output status, output handle_out, output slot_index,
                    input ready);
    modport sink   (input valid, input status, input handle_out, input slot_index,
                    output ready);
endinterface

// ----- design/hashed_id_registry_unit.sv -----
// Hashed id registry: a 64-slot table of id and handle pairs with linear probing.
// Depends on hir_pkg, hir_req_if, hir_rsp_if, hir_hash, hir_ram and the assert header.
//
// Use: i_req carries items (opcode, ext_id, handle_in); opcode insert stores the
// handle under the id in the first empty slot from the id's home slot to the last
// slot, opcode lookup finds the first slot from home whose id matches. o_rsp
// returns one item per request: status (ok, table full, not found), handle_out
// and slot_index.
// Timing: one item at a time. After acceptance the hash runs its mixing steps,
// the home slot is read, the probe checks one slot per cycle until it finds a
// match or reaches the last slot, and the output register is loaded. The next
// item is taken the cycle after the load.
// A full table refuses an insert right after the hash, without a probe.
// i_req.ready is high only while no item is in work.
// Reset: the slot ids read as empty at once (a valid bit per slot), the entry
// count clears and both channels go idle; no clearing pass is needed.
// Stall: a finished result waits in the output register; the next item is taken
// and worked on, and its result waits until the held one is taken.
module hashed_id_registry_unit (
    input  logic      i_clk,
    input  logic      i_rst_n,
    hir_req_if.sink   i_req,
    hir_rsp_if.source o_rsp
);
    import hir_pkg::*;

    t_ctl_state            r_state;
    t_ctl_state            n_state;
    logic                  r_op;
    logic [KEY_W-1:0]      r_id;
    logic [HANDLE_W-1:0]   r_handle;
    logic [SLOT_W-1:0]     r_cur;
    logic [SLOT_W-1:0]     n_cur;
    logic [COUNT_W-1:0]    r_count;
    logic [TABLE_SLOTS-1:0] r_slot_valid;
    logic                  r_rd_valid;

    t_status               r_res_status;
    t_status               n_res_status;
    logic [HANDLE_W-1:0]   r_res_handle;
    logic [HANDLE_W-1:0]   n_res_handle;
    logic [SLOT_W-1:0]     r_res_slot;
    logic [SLOT_W-1:0]     n_res_slot;

    logic                  r_out_valid;
    t_status               r_out_status;
    logic [HANDLE_W-1:0]   r_out_handle;
    logic [SLOT_W-1:0]     r_out_slot;

    logic                  w_accept;
    logic                  w_hash_start;
    logic                  w_hash_done;
    logic [HOME_W-1:0]     w_home;
    logic                  w_home_ok;
    logic                  w_we;
    logic [SLOT_W-1:0]     w_raddr;
    logic [ENTRY_W-1:0]    w_q;
    logic [KEY_W-1:0]      w_rd_id;
    logic                  w_match;
    logic                  w_load_out;
    t_status               w_fail_status;

    assign w_accept    = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == CS_IDLE);

    // hash unit
    hir_hash u_hash (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_hash_start),
        .i_id    (KEY_W'(i_req.ext_id)),
        .o_done  (w_hash_done),
        .o_home  (w_home)
    );

    // slot memory: {handle, id}
    hir_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_SLOTS)
    ) u_slots (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_cur),
        .i_wdata ({r_handle, r_id}),
        .i_raddr (w_raddr),
        .o_rdata (w_q)
    );

    assign w_home_ok     = (32'(w_home) < 32'(TABLE_SLOTS));
    assign w_rd_id       = r_rd_valid ? w_q[KEY_W-1:0] : '0;
    assign w_match       = (r_op == OP_INSERT) ? (w_rd_id == '0) : (w_rd_id == r_id);
    assign w_fail_status = (r_op == OP_INSERT) ? ST_FULL : ST_NOT_FOUND;

    // control state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= CS_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state, probe address and result
    always_comb begin
        n_state      = r_state;
        n_cur        = r_cur;
        n_res_status = r_res_status;
        n_res_handle = r_res_handle;
        n_res_slot   = r_res_slot;
        w_hash_start = 1'b0;
        w_we         = 1'b0;
        w_load_out   = 1'b0;
        w_raddr      = r_cur + SLOT_W'(1);
        case (r_state)
            CS_IDLE: begin
                if (i_req.valid) begin
                    w_hash_start = 1'b1;
                    n_state      = CS_HASH;
                end
            end
            CS_HASH: begin
                if (w_hash_done) begin
                    if (r_op == OP_INSERT && r_count == COUNT_W'(MAX_ENTRIES)) begin
                        n_res_status = ST_FULL;
                        n_res_handle = '0;
                        n_res_slot   = '0;
                        n_state      = CS_DONE;
                    end else if (!w_home_ok) begin
                        n_res_status = w_fail_status;
                        n_res_handle = '0;
                        n_res_slot   = '0;
                        n_state      = CS_DONE;
                    end else begin
                        // start the probe at the home slot
                        w_raddr = SLOT_W'(w_home);
                        n_cur   = SLOT_W'(w_home);
                        n_state = CS_SCAN;
                    end
                end
            end
            CS_SCAN: begin
                if (w_match) begin
                    n_res_status = ST_OK;
                    n_res_handle = (r_op == OP_LOOKUP) ? w_q[ENTRY_W-1:KEY_W] : '0;
                    n_res_slot   = r_cur;
                    w_we         = (r_op == OP_INSERT);
                    n_state      = CS_DONE;
                end else if (r_cur == LAST_SLOT) begin
                    n_res_status = w_fail_status;
                    n_res_handle = '0;
                    n_res_slot   = '0;
                    n_state      = CS_DONE;
                end else begin
                    n_cur = r_cur + SLOT_W'(1);
                end
            end
            CS_DONE: begin
                if (!r_out_valid || o_rsp.ready) begin
                    w_load_out = 1'b1;
                    n_state    = CS_IDLE;
                end
            end
            default: begin
                n_state = CS_IDLE;
            end
        endcase
    end

    // hold the accepted item and the probe result
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op     <= i_req.opcode;
            r_id     <= KEY_W'(i_req.ext_id);
            r_handle <= i_req.handle_in;
        end
        r_cur        <= n_cur;
        r_res_status <= n_res_status;
        r_res_handle <= n_res_handle;
        r_res_slot   <= n_res_slot;
    end

    // slot valid bits and entry count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_valid <= '0;
            r_count      <= '0;
            r_rd_valid   <= 1'b0;
        end else begin
            r_rd_valid <= r_slot_valid[w_raddr];
            if (w_we) begin
                r_slot_valid[r_cur] <= 1'b1;
                r_count             <= r_count + COUNT_W'(1);
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out_status <= r_res_status;
            r_out_handle <= r_res_handle;
            r_out_slot   <= r_res_slot;
        end
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.status     = r_out_status;
    assign o_rsp.handle_out = r_out_handle;
    assign o_rsp.slot_index = SLOT_OUT_W'(r_out_slot);

`include "hashed_id_registry_unit_assert.svh"

    `HIR_ASSERT_SAME(a_count_bound, 1'b1, r_count <= COUNT_W'(MAX_ENTRIES))
    `HIR_ASSERT_SAME(a_write_in_scan, w_we, r_state == CS_SCAN && r_op == OP_INSERT)
    `HIR_ASSERT_NEXT(a_write_counts, w_we, r_count == $past(r_count) + COUNT_W'(1))
    `HIR_ASSERT_NEXT(a_accept_hash, w_accept, r_state == CS_HASH)
    `HIR_ASSERT_SAME(a_load_free, w_load_out, !r_out_valid || o_rsp.ready)
endmodule

// ----- design/hir_ram.sv -----
// Generic single-write, single-read synchronous RAM with a registered read.
// No package dependencies.
module hir_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ----- design/hir_hash.sv -----
// Multi-cycle 64-bit integer hash of an id, one mixing step per cycle.
// Depends on hir_pkg; produces the home slot of the probe.
module hir_hash (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [hir_pkg::KEY_W-1:0]  i_id,
    output logic                       o_done,
    output logic [hir_pkg::HOME_W-1:0] o_home
);
    import hir_pkg::*;

    t_hash_step        r_step;
    t_hash_step        n_step;
    logic [HASH_W-1:0] r_h;
    logic [HASH_W-1:0] n_h;
    logic [HASH_W-1:0] w_fold;

    // step sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= HS_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

    always_ff @(posedge i_clk) begin
        r_h <= n_h;
    end

    // apply one mixing step per cycle
    always_comb begin
        n_step = r_step;
        n_h    = r_h;
        case (r_step)
            HS_IDLE: begin
                if (i_start) begin
                    n_h    = HASH_W'(i_id);
                    n_step = HS_ADD18;
                end
            end
            HS_ADD18: begin
                n_h    = (~r_h) + (r_h << 18);
                n_step = HS_XOR31;
            end
            HS_XOR31: begin
                n_h    = r_h ^ (r_h >> 31);
                n_step = HS_MUL21;
            end
            HS_MUL21: begin
                // times 21 as 16 + 4 + 1
                n_h    = (r_h << 4) + (r_h << 2) + r_h;
                n_step = HS_XOR11;
            end
            HS_XOR11: begin
                n_h    = r_h ^ (r_h >> 11);
                n_step = HS_ADD6;
            end
            HS_ADD6: begin
                n_h    = r_h + (r_h << 6);
                n_step = HS_XOR22;
            end
            HS_XOR22: begin
                n_h    = r_h ^ (r_h >> 22);
                n_step = HS_DONE;
            end
            HS_DONE: begin
                n_step = HS_IDLE;
            end
            default: begin
                n_step = HS_IDLE;
            end
        endcase
    end

    // fold the mixed value into a home slot
    assign w_fold = ((r_h >> 3) ^ HASH_XOR_MASK) % MAX_ENTRIES;
    assign o_home = HOME_W'(w_fold);
    assign o_done = (r_step == HS_DONE);
endmodule

// ----- sim/hashed_id_registry_unit_tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for hashed_id_registry_unit: directed and random insert and
// lookup items, each result checked against an in-bench copy of the slot table.
// Depends on hir_pkg, hir_req_if, hir_rsp_if and the design sources.
module hashed_id_registry_unit_tb;
    import hir_pkg::*;

    localparam int CLK_HALF     = 6;
    localparam int RESET_CYCLES = 3;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int DRAIN_CYCLES = 80;
    localparam int REPORT_MAX   = 10;
    localparam int PHASE_ITEMS  = 660;

    typedef struct packed {
        logic                op;
        logic [EXT_ID_W-1:0] id;
        logic [HANDLE_W-1:0] handle;
    } t_registry_req;

    typedef struct packed {
        t_status               status;
        logic [HANDLE_W-1:0]   handle;
        logic [SLOT_OUT_W-1:0] slot;
    } t_registry_rsp;

    logic i_clk;
    logic i_rst_n;
    logic rsp_ready_q = 1'b0;

    hir_req_if req_ch();
    hir_rsp_if rsp_ch();

    assign rsp_ch.ready = rsp_ready_q;

    hashed_id_registry_unit i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    // shadow copy of the slot table
    logic [EXT_ID_W-1:0] slot_id_mem     [TABLE_SLOTS];
    logic [HANDLE_W-1:0] slot_handle_mem [TABLE_SLOTS];
    bit                  handle_valid    [TABLE_SLOTS];
    int                  entry_total = 0;

    t_registry_rsp pending_rsp_q [$];
    int fault_count    = 0;
    int cycle_count    = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int send_run       = 0;
    int recv_run       = 0;

    // free-running clock
    always begin
        i_clk = 1'b0;
        #CLK_HALF;
        i_clk = 1'b1;
        #CLK_HALF;
    end

    // mix the zero-extended id and reduce it to a home slot
    function automatic int home_of(logic [EXT_ID_W-1:0] id);
        logic [HASH_W-1:0] h;
        h = HASH_W'(id);
        h = (~h) + (h << 18);
        h = h ^ (h >> 31);
        h = h * 64'd21;
        h = h ^ (h >> 11);
        h = h + (h << 6);
        h = h ^ (h >> 22);
        h = ((h >> 3) ^ HASH_XOR_MASK) % 64'(MAX_ENTRIES);
        return int'(h);
    endfunction

    // apply one insert or lookup to the shadow table and return its result
    function automatic t_registry_rsp registry_apply(t_registry_req item);
        t_registry_rsp res;
        bit            done;
        done       = 1'b0;
        res.handle = '0;
        res.slot   = '0;
        if (item.op == OP_INSERT) begin
            res.status = ST_FULL;
            if (entry_total != MAX_ENTRIES) begin
                for (int i = home_of(item.id); i < TABLE_SLOTS && !done; i++) begin
                    if (slot_id_mem[i] == '0) begin
                        slot_id_mem[i]     = item.id;
                        slot_handle_mem[i] = item.handle;
                        handle_valid[i]    = 1'b1;
                        entry_total++;
                        res.status = ST_OK;
                        res.slot   = SLOT_OUT_W'(i);
                        done       = 1'b1;
                    end
                end
            end
        end else begin
            res.status = ST_NOT_FOUND;
            // keep scanning past empty slots up to the last one
            for (int i = home_of(item.id); i < TABLE_SLOTS && !done; i++) begin
                if (slot_id_mem[i] == item.id) begin
                    res.status = ST_OK;
                    res.handle = slot_handle_mem[i];
                    res.slot   = SLOT_OUT_W'(i);
                    done       = 1'b1;
                end
            end
        end
        return res;
    endfunction

    // a lookup of id zero may only land on an empty slot whose handle was written
    function automatic bit zero_lookup_safe();
        for (int i = home_of('0); i < TABLE_SLOTS; i++) begin
            if (slot_id_mem[i] == '0) return handle_valid[i];
        end
        return 1'b1;
    endfunction

    function automatic int lowest_empty_slot();
        for (int i = 0; i < TABLE_SLOTS; i++) begin
            if (slot_id_mem[i] == '0) return i;
        end
        return -1;
    endfunction

    // search for a nonzero id that hashes to the given home slot
    function automatic logic [EXT_ID_W-1:0] id_with_home(int target);
        logic [EXT_ID_W-1:0] cand;
        do begin
            cand = $urandom;
        end while (cand == '0 || home_of(cand) != target);
        return cand;
    endfunction

    // pick an id that is present in the table, or a random one when it is empty
    function automatic logic [EXT_ID_W-1:0] stored_id();
        int start;
        int idx;
        start = $urandom_range(TABLE_SLOTS - 1);
        for (int j = 0; j < TABLE_SLOTS; j++) begin
            idx = (start + j) % TABLE_SLOTS;
            if (slot_id_mem[idx] != '0) return slot_id_mem[idx];
        end
        return $urandom | 32'h1;
    endfunction

    function automatic logic [HANDLE_W-1:0] random_handle();
        case ($urandom_range(15))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic t_registry_req random_item();
        t_registry_req item;
        int            slot;
        item.handle = random_handle();
        if ($urandom_range(99) < 15) begin
            item.op = OP_INSERT;
            case ($urandom_range(9))
                0, 1, 2, 3: item.id = $urandom;
                4, 5: begin
                    slot    = lowest_empty_slot();
                    item.id = id_with_home(slot >= 0 ? slot : $urandom_range(TABLE_SLOTS - 1));
                end
                6:       item.id = id_with_home($urandom_range(TABLE_SLOTS - 1));
                7:       item.id = stored_id();
                8:       item.id = '0;
                default: item.id = $urandom_range(255, 1);
            endcase
        end else begin
            item.op = OP_LOOKUP;
            case ($urandom_range(9))
                0, 1, 2, 3, 4, 5: item.id = stored_id();
                6, 7:             item.id = $urandom;
                8:                item.id = zero_lookup_safe() ? '0 : stored_id();
                default:          item.id = id_with_home($urandom_range(TABLE_SLOTS - 1));
            endcase
            if (item.id == '0 && !zero_lookup_safe()) item.id = 32'h1;
        end
        return item;
    endfunction

    // per-cycle idle decisions, with occasional stretches of no idling
    function automatic bit sender_idles();
        if (send_idle_pct == 0) return 1'b0;
        if (send_run > 0) begin
            send_run--;
            return 1'b0;
        end
        if ($urandom_range(99) < 2) begin
            send_run = $urandom_range(60, 20);
            return 1'b0;
        end
        return $urandom_range(99) < send_idle_pct;
    endfunction

    function automatic bit receiver_stalls();
        if (recv_stall_pct == 0) return 1'b0;
        if (recv_run > 0) begin
            recv_run--;
            return 1'b0;
        end
        if ($urandom_range(99) < 2) begin
            recv_run = $urandom_range(60, 20);
            return 1'b0;
        end
        return $urandom_range(99) < recv_stall_pct;
    endfunction

    // drive one item, hold it until accepted, then queue its expected result
    task automatic send_item(logic op, logic [EXT_ID_W-1:0] id, logic [HANDLE_W-1:0] handle);
        t_registry_req item;
        item = '{op: op, id: id, handle: handle};
        while (sender_idles()) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.opcode    <= op;
        req_ch.ext_id    <= id;
        req_ch.handle_in <= handle;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        pending_rsp_q.push_back(registry_apply(item));
    endtask

    task automatic test_lookup_misses();
        send_item(OP_LOOKUP, '1, random_handle());
        send_item(OP_LOOKUP, 32'h1, random_handle());
        // scan all empty slots from the first one to the end
        send_item(OP_LOOKUP, id_with_home(0), random_handle());
    endtask

    task automatic test_field_extremes();
        send_item(OP_INSERT, '1, '1);
        send_item(OP_INSERT, 32'h1, '0);
        send_item(OP_INSERT, 32'h8000_0000, 64'h8000_0000_0000_0001);
        send_item(OP_INSERT, 32'h5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
        send_item(OP_LOOKUP, '1, '0);
        send_item(OP_LOOKUP, 32'h1, '1);
        send_item(OP_LOOKUP, 32'h8000_0000, '0);
        send_item(OP_LOOKUP, 32'h5555_5555, '0);
    endtask

    task automatic test_id_zero();
        // an id-zero insert leaves its slot empty, so the next one reuses it
        send_item(OP_INSERT, '0, 64'h0123_4567_89AB_CDEF);
        if (zero_lookup_safe()) send_item(OP_LOOKUP, '0, '0);
        send_item(OP_INSERT, '0, 64'hFEDC_BA98_7654_3210);
        if (zero_lookup_safe()) send_item(OP_LOOKUP, '0, '0);
        send_item(OP_INSERT, id_with_home(home_of('0)), random_handle());
        if (zero_lookup_safe()) send_item(OP_LOOKUP, '0, '0);
    endtask

    task automatic test_duplicate_ids();
        logic [EXT_ID_W-1:0] dup;
        dup = $urandom | 32'h1;
        send_item(OP_INSERT, dup, 64'h1111_2222_3333_4444);
        send_item(OP_INSERT, dup, 64'h5555_6666_7777_8888);
        send_item(OP_LOOKUP, dup, '0);
    endtask

    task automatic test_probe_end();
        logic [EXT_ID_W-1:0] near_end;
        logic [EXT_ID_W-1:0] at_end;
        near_end = id_with_home(TABLE_SLOTS - 2);
        at_end   = id_with_home(TABLE_SLOTS - 1);
        // fill the last two slots, then find no empty slot from the last home
        send_item(OP_INSERT, near_end, random_handle());
        send_item(OP_INSERT, near_end ^ 32'h0, random_handle());
        send_item(OP_INSERT, at_end, random_handle());
        send_item(OP_LOOKUP, at_end, '0);
        send_item(OP_LOOKUP, near_end, '0);
    endtask

    task automatic run_random_phase(int count, int idle_pct, int stall_pct);
        t_registry_req item;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        send_run       = 0;
        recv_run       = 0;
        for (int n = 0; n < count; n++) begin
            item = random_item();
            send_item(item.op, item.id, item.handle);
        end
    endtask

    task automatic test_random_traffic();
        run_random_phase(PHASE_ITEMS, 15, 84);
        run_random_phase(PHASE_ITEMS, 84, 15);
        run_random_phase(PHASE_ITEMS, 0, 0);
    endtask

    task automatic test_table_full();
        // place each insert at the lowest empty slot until the count saturates
        while (entry_total < MAX_ENTRIES && lowest_empty_slot() >= 0) begin
            send_item(OP_INSERT, id_with_home(lowest_empty_slot()), random_handle());
        end
        send_item(OP_INSERT, $urandom, random_handle());
        send_item(OP_INSERT, '0, random_handle());
        send_item(OP_LOOKUP, stored_id(), '0);
        send_item(OP_LOOKUP, stored_id(), '0);
        send_item(OP_LOOKUP, $urandom | 32'h1, '0);
        if (zero_lookup_safe()) send_item(OP_LOOKUP, '0, '0);
    endtask

    // drive result-side backpressure
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_ready_q <= 1'b0;
        end else begin
            rsp_ready_q <= !receiver_stalls();
        end
    end

    // compare each accepted result with the oldest expectation
    always @(posedge i_clk) begin
        t_registry_rsp want;
        if (i_rst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            if (pending_rsp_q.size() == 0) begin
                fault_count++;
                if (fault_count <= REPORT_MAX) begin
                    $display("unexpected result: status %0d handle %h slot %0d",
                             rsp_ch.status, rsp_ch.handle_out, rsp_ch.slot_index);
                end
            end else begin
                want = pending_rsp_q.pop_front();
                if (rsp_ch.status !== want.status || rsp_ch.handle_out !== want.handle ||
                    rsp_ch.slot_index !== want.slot) begin
                    fault_count++;
                    if (fault_count <= REPORT_MAX) begin
                        $display({"mismatch: expected status %0d handle %h slot %0d, ",
                                  "got %0d %h %0d"},
                                 want.status, want.handle, want.slot,
                                 rsp_ch.status, rsp_ch.handle_out, rsp_ch.slot_index);
                    end
                end
            end
        end
    end

    // end the run if it hangs
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        i_rst_n          = 1'b0;
        req_ch.valid     = 1'b0;
        req_ch.opcode    = OP_INSERT;
        req_ch.ext_id    = '0;
        req_ch.handle_in = '0;
        for (int i = 0; i < TABLE_SLOTS; i++) begin
            slot_id_mem[i]     = '0;
            slot_handle_mem[i] = '0;
            handle_valid[i]    = 1'b0;
        end
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_lookup_misses();
        test_field_extremes();
        test_id_zero();
        test_duplicate_ids();
        test_probe_end();
        test_random_traffic();
        test_table_full();
        req_ch.valid <= 1'b0;

        // drain outstanding results, then watch for strays
        while (pending_rsp_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fault_count == 0 && pending_rsp_q.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
